### sv/vfdd_pkg.sv
// ----------------------------------------------------------------------------
// vfdd_pkg - shared types and constants of the frame drop decider
// Opcodes, picture types, datapath widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package vfdd_pkg;

  localparam int DIVD_W = 48;   // divider dividend and quotient width
  localparam int DIVS_W = 18;   // divider divisor width
  localparam int MULA_W = 49;   // signed multiplier operand a
  localparam int MULB_W = 19;   // signed multiplier operand b

  localparam logic [DIVD_W-1:0] PERIOD_NUM = 48'd1001000000;

  localparam logic [2:0] OP_NEW_PIC  = 3'd0;
  localparam logic [2:0] OP_CHOOSE   = 3'd1;
  localparam logic [2:0] OP_TRASH    = 3'd2;
  localparam logic [2:0] OP_DEC_START = 3'd3;
  localparam logic [2:0] OP_DEC_END  = 3'd4;
  localparam logic [2:0] OP_RESET    = 3'd5;

  localparam logic [1:0] PIC_NONE = 2'd0;
  localparam logic [1:0] PIC_I    = 2'd1;
  localparam logic [1:0] PIC_P    = 2'd2;
  localparam logic [1:0] PIC_B    = 2'd3;

  localparam logic CFG_FPS_RATE   = 1'b0;
  localparam logic CFG_NEVER_SKIP = 1'b1;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_Q_GO   = 20'h00002,
    ST_Q_WAIT = 20'h00004,
    ST_R_MUL  = 20'h00008,
    ST_R_GO   = 20'h00010,
    ST_R_WAIT = 20'h00020,
    ST_C_M0   = 20'h00040,
    ST_C_M1   = 20'h00080,
    ST_C_M2   = 20'h00100,
    ST_C_M3   = 20'h00200,
    ST_C_M4   = 20'h00400,
    ST_C_E1   = 20'h00800,
    ST_C_E2   = 20'h01000,
    ST_C_E3   = 20'h02000,
    ST_N_MUL  = 20'h04000,
    ST_N_UPD  = 20'h08000,
    ST_D_MUL  = 20'h10000,
    ST_D_GO   = 20'h20000,
    ST_D_WAIT = 20'h40000,
    ST_OUT    = 20'h80000
  } state_t;

endpackage
`default_nettype wire

### sv/vfdd_div.sv
// ----------------------------------------------------------------------------
// vfdd_div - iterative restoring divider
// One quotient bit per cycle, most significant first; done pulses at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module vfdd_div
  import vfdd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [DIVD_W-1:0]      quotient
);

  logic [DIVS_W:0]         rem_r;
  logic [DIVD_W-1:0]       q_r;
  logic [DIVS_W-1:0]       dsr_r;
  logic [$clog2(DIVD_W):0] cnt_r;
  logic                    busy_r, done_r;
  logic [DIVS_W:0]         trial;
  logic                    fits;

  assign trial = {rem_r[DIVS_W-1:0], q_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= ($clog2(DIVD_W)+1)'(DIVD_W);
        rem_r  <= '0;
        q_r    <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        // shift in the next dividend bit, take the quotient bit in its place
        rem_r <= fits ? trial - {1'b0, dsr_r} : trial;
        q_r   <= {q_r[DIVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

### sv/vfdd_mul.sv
// ----------------------------------------------------------------------------
// vfdd_mul - shared signed multiplier
// Registered product, low 64 bits, in the cycle after the operands.
// ----------------------------------------------------------------------------
`default_nettype none
module vfdd_mul
  import vfdd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MULA_W-1:0] a,
  input  wire logic signed [MULB_W-1:0] b,
  output logic [63:0]                   p
);

  logic signed [MULA_W+MULB_W-1:0] full;
  logic [63:0]                     p_r;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p_r <= full[63:0];
  end

  assign p = p_r;

endmodule
`default_nettype wire

### sv/video_frame_drop_decider.sv
// ----------------------------------------------------------------------------
// video_frame_drop_decider - decode or drop decision for I/P/B pictures
// ----------------------------------------------------------------------------
// Input words carry one timed event each (opcode on in_tuser): new picture,
// choose, trash, decode start, decode end, reference reset. Each event gives
// exactly one output word: decode_ok and the current presentation date.
// The block handles one word at a time; in_tready is high only when idle.
// Trash, decode start, reset, ignored events, choose with never_skip or no
// picture type, and decode end with a discarded sample need no division.
// New picture and choose derive the picture period through the shared
// restoring divider twice (48 iterations each) and the shared multiplier;
// choose then runs its multiply and compare steps. Decode end runs one
// division when the sample is kept.
// The block is ready for the next word in the cycle in which out_tvalid rises.
// A finished word waits in the output register while out_tready is low; the
// sequencer holds in its output state until that register is free.
// Reset (rst_n low, synchronous) restores all statistics, the GOP pattern,
// dates, the rate register 25025 and never_skip 0; no word is pending.
// Configuration writes through cfg_wr_en are taken in any cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module video_frame_drop_decider
  import vfdd_pkg::*;
#(
  parameter int AVERAGE_DEPTH    = 8,
  parameter int RATE_UNIT        = 1000,
  parameter int TICKS_PER_SECOND = 1000000
)(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // now_time[62:0], picture_type[64:63], render_time[88:65],
  // repeat_fields[90:89], next_presentation[153:91],
  // next_decode_stamp[216:154], play_rate[232:217], garbage[233], zero pad
  input  wire logic [239:0] in_tdata,
  // opcode[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // decode_ok[0], presentation_date[63:1]
  output logic [63:0]       out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [17:0]  cfg_wdata
);

  localparam logic [63:0] MARGIN    = 64'(longint'(TICKS_PER_SECOND) * 75 / 1000);
  localparam logic [63:0] FIRST_LIM = 64'(longint'(TICKS_PER_SECOND) * 3 / 10);
  localparam logic [7:0]  AVG_DEPTH = 8'(AVERAGE_DEPTH);

  state_t state_r, state_nxt;

  // configuration
  logic [17:0] fps_rate_r;
  logic        never_skip_r;

  // held input word
  logic [2:0]  op_r;
  logic [62:0] now_r;
  logic [1:0]  ptype_r;
  logic [1:0]  rep_r;
  logic [62:0] npts_r, ndts_r;
  logic [15:0] rate_r;

  // decider state
  logic [31:0] mean_r [3];
  logic [7:0]  cnt_r  [3];
  logic [7:0]  p_per_gop_r, p_seen_r, b_per_ref_r, b_seen_r;
  logic [1:0]  refs_held_r, refs_trash_r, refs_dec_r;
  logic [63:0] cur_date_r, back_date_r, dec_start_r;
  logic [1:0]  cur_fields_r, back_fields_r;
  logic [15:0] stored_rate_r;
  logic [23:0] stored_render_r;

  // work registers
  logic [DIVD_W-1:0] period_r;
  logic [63:0]       k_r, lim_r, bp1_r, pk_r, pts_r, thr_r, thr01_r, d_r, d2_r;
  logic [35:0]       el_r;
  logic              ok_r;
  logic              out_valid_r, out_ok_r;
  logic [62:0]       out_date_r;

  // shared units
  logic              div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dd, div_q;
  logic [DIVS_W-1:0] div_ds;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic [63:0]       mul_p;

  vfdd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dd),
    .divisor(div_ds), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  vfdd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  logic [1:0]  idx;
  logic [8:0]  bp1_small;
  logic [63:0] el_full, el_pos, tau0, tau1, tau_sel, new_date, num;
  logic        keep;
  logic        lim_gt_i, bp_gt_p, d_gt_thr, d_gt_0, d2_gt_thr01, decide;
  logic        accept;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign idx       = ptype_r - 2'd1;
  assign bp1_small = {1'b0, b_per_ref_r} + 9'd1;

  assign tau0 = 64'(mean_r[0]) + 64'(mean_r[0] >> 1) + 64'(stored_render_r);
  assign tau1 = 64'(mean_r[1]) + 64'(mean_r[1] >> 1) + 64'(stored_render_r);
  assign tau_sel = 64'(mean_r[idx]) + 64'(mean_r[idx] >> 1) + 64'(stored_render_r);

  // decode elapsed time, clamped at zero
  assign el_full = {1'b0, now_r} - dec_start_r;
  assign el_pos  = el_full[63] ? 64'd0 : el_full;
  assign keep    = (el_pos < 64'(mean_r[idx]) * 64'd3) ||
                   (cnt_r[idx] == 8'd0 && el_pos < FIRST_LIM);
  assign num     = mul_p + 64'(el_r);

  assign new_date = cur_date_r + mul_p;

  assign lim_gt_i    = $signed(lim_r) > $signed(64'(mean_r[0]));
  assign bp_gt_p     = $signed(bp1_r) > $signed(64'(mean_r[1]));
  assign d_gt_thr    = $signed(d_r) > $signed(thr_r);
  assign d_gt_0      = $signed(d_r) > 64'sd0;
  assign d2_gt_thr01 = $signed(d2_r) > $signed(thr01_r);

  always_comb begin
    case (ptype_r)
      PIC_I:   decide = lim_gt_i ? 1'b1 : d_gt_thr;
      PIC_P: begin
        if (refs_held_r < 2'd1 || !lim_gt_i) decide = 1'b0;
        else if (bp_gt_p)                    decide = d_gt_0;
        else                                 decide = d_gt_thr && d2_gt_thr01;
      end
      PIC_B:   decide = (refs_held_r >= 2'd2) && bp_gt_p && d_gt_thr;
      default: decide = 1'b0;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    div_start = 1'b0;
    div_dd    = PERIOD_NUM;
    div_ds    = (fps_rate_r == '0) ? DIVS_W'(1) : fps_rate_r;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_Q_GO: div_start = 1'b1;
      ST_R_MUL: begin
        mul_a = MULA_W'(div_q);
        mul_b = MULB_W'((op_r == OP_NEW_PIC) ? rate_r : stored_rate_r);
      end
      ST_R_GO: begin
        div_start = 1'b1;
        div_dd    = mul_p[DIVD_W-1:0];
        div_ds    = DIVS_W'(RATE_UNIT);
      end
      ST_C_M0: begin
        mul_a = MULA_W'($signed({1'b0, p_per_gop_r} - {1'b0, p_seen_r}));
        mul_b = MULB_W'(bp1_small);
      end
      ST_C_M1: begin
        mul_a = MULA_W'(p_per_gop_r);
        mul_b = MULB_W'(bp1_small);
      end
      ST_C_M2: begin
        mul_a = MULA_W'(period_r);
        mul_b = MULB_W'(mul_p[16:0] + 17'd1);
      end
      ST_C_M3: begin
        mul_a = MULA_W'(period_r);
        mul_b = MULB_W'(bp1_small);
      end
      ST_C_M4: begin
        mul_a = MULA_W'(period_r);
        mul_b = k_r[MULB_W-1:0];
      end
      ST_N_MUL: begin
        mul_a = MULA_W'(period_r >> 1);
        mul_b = MULB_W'(cur_fields_r);
      end
      ST_D_MUL: begin
        mul_a = MULA_W'(mean_r[idx]);
        mul_b = MULB_W'(cnt_r[idx]);
      end
      ST_D_GO: begin
        div_start = 1'b1;
        div_dd    = num[DIVD_W-1:0];
        div_ds    = DIVS_W'({1'b0, cnt_r[idx]} + 9'd1);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_OUT;
          case (in_tuser)
            OP_NEW_PIC: state_nxt = ST_Q_GO;
            OP_CHOOSE:
              if (!never_skip_r && in_tdata[64:63] != PIC_NONE) state_nxt = ST_Q_GO;
            OP_DEC_END:
              if (!in_tdata[233] && in_tdata[64:63] != PIC_NONE) state_nxt = ST_D_MUL;
            default: ;
          endcase
        end
      end
      ST_Q_GO:   state_nxt = ST_Q_WAIT;
      ST_Q_WAIT: if (div_done) state_nxt = ST_R_MUL;
      ST_R_MUL:  state_nxt = ST_R_GO;
      ST_R_GO:   state_nxt = ST_R_WAIT;
      ST_R_WAIT: if (div_done) state_nxt = (op_r == OP_NEW_PIC) ? ST_N_MUL : ST_C_M0;
      ST_C_M0:   state_nxt = ST_C_M1;
      ST_C_M1:   state_nxt = ST_C_M2;
      ST_C_M2:   state_nxt = ST_C_M3;
      ST_C_M3:   state_nxt = ST_C_M4;
      ST_C_M4:   state_nxt = ST_C_E1;
      ST_C_E1:   state_nxt = ST_C_E2;
      ST_C_E2:   state_nxt = ST_C_E3;
      ST_C_E3:   state_nxt = ST_OUT;
      ST_N_MUL:  state_nxt = ST_N_UPD;
      ST_N_UPD:  state_nxt = ST_OUT;
      ST_D_MUL:  state_nxt = keep ? ST_D_GO : ST_OUT;
      ST_D_GO:   state_nxt = ST_D_WAIT;
      ST_D_WAIT: if (div_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      fps_rate_r      <= 18'd25025;
      never_skip_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mean_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      p_per_gop_r     <= 8'd5;
      p_seen_r        <= 8'd5;
      b_per_ref_r     <= 8'd1;
      b_seen_r        <= 8'd1;
      refs_held_r     <= '0;
      refs_trash_r    <= '0;
      refs_dec_r      <= '0;
      cur_date_r      <= '0;
      back_date_r     <= '0;
      cur_fields_r    <= '0;
      back_fields_r   <= '0;
      stored_rate_r   <= 16'(RATE_UNIT);
      stored_render_r <= '0;
      dec_start_r     <= '0;
      out_valid_r     <= 1'b0;
      ok_r            <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FPS_RATE:   fps_rate_r   <= cfg_wdata;
          CFG_NEVER_SKIP: never_skip_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r      <= in_tuser;
            now_r     <= in_tdata[62:0];
            ptype_r   <= in_tdata[64:63];
            rep_r     <= in_tdata[90:89];
            npts_r    <= in_tdata[153:91];
            ndts_r    <= in_tdata[216:154];
            rate_r    <= in_tdata[232:217];
            ok_r      <= (in_tuser == OP_CHOOSE) && never_skip_r;
            case (in_tuser)
              OP_CHOOSE: begin
                if (!never_skip_r) stored_render_r <= in_tdata[88:65];
              end
              OP_TRASH: refs_held_r <= refs_trash_r;
              OP_DEC_START: begin
                dec_start_r <= {1'b0, in_tdata[62:0]};
                refs_held_r <= refs_dec_r;
              end
              OP_RESET: begin
                refs_held_r  <= '0;
                refs_trash_r <= '0;
                refs_dec_r   <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_R_WAIT: if (div_done) period_r <= div_q;
        ST_C_M1: k_r <= mul_p - 64'd1;
        ST_C_M3: lim_r <= mul_p;
        ST_C_M4: bp1_r <= mul_p;
        ST_C_E1: begin
          pk_r    <= mul_p;
          thr_r   <= tau_sel + MARGIN;
          thr01_r <= tau1 + tau0 + MARGIN;
          // pick the presentation time of the picture
          if (ptype_r == PIC_B)          pts_r <= cur_date_r;
          else if (back_date_r != '0)    pts_r <= back_date_r;
          else if (ptype_r == PIC_I)     pts_r <= cur_date_r + bp1_r + 64'(period_r);
          else                           pts_r <= cur_date_r + bp1_r;
        end
        ST_C_E2: begin
          d_r  <= pts_r - {1'b0, now_r};
          d2_r <= pts_r - {1'b0, now_r} + pk_r;
        end
        ST_C_E3: ok_r <= decide;
        ST_N_UPD: begin
          stored_rate_r <= rate_r;
          case (ptype_r)
            PIC_I: begin
              if (p_seen_r != '0 && p_seen_r != p_per_gop_r) p_per_gop_r <= p_seen_r;
              p_seen_r     <= '0;
              b_seen_r     <= '0;
              refs_trash_r <= '0;
              refs_dec_r   <= (refs_held_r < 2'd2) ? refs_held_r + 2'd1 : refs_held_r;
            end
            PIC_P: begin
              p_seen_r <= p_seen_r + 8'd1;
              if (b_seen_r != '0 && b_seen_r != b_per_ref_r) b_per_ref_r <= b_seen_r;
              b_seen_r     <= '0;
              refs_dec_r   <= 2'd2;
              refs_trash_r <= '0;
            end
            PIC_B: begin
              b_seen_r     <= b_seen_r + 8'd1;
              refs_dec_r   <= refs_held_r;
              refs_trash_r <= refs_held_r;
            end
            default: ;
          endcase
          if (ptype_r == PIC_B) begin
            cur_fields_r <= rep_r;
            cur_date_r   <= (npts_r != '0) ? {1'b0, npts_r} : new_date;
          end else begin
            cur_fields_r  <= back_fields_r;
            back_fields_r <= rep_r;
            if (back_date_r != '0) begin
              cur_date_r <= back_date_r;
            end else if (ndts_r != '0) begin
              cur_date_r <= {1'b0, ndts_r};
            end else begin
              cur_date_r <= new_date;
            end
            // take the new backward date, else drop the one just consumed
            if (npts_r != '0) begin
              back_date_r <= {1'b0, npts_r};
            end else if (back_date_r != '0) begin
              back_date_r <= '0;
            end
          end
        end
        ST_D_MUL: el_r <= el_pos[35:0];
        ST_D_WAIT: begin
          if (div_done) begin
            mean_r[idx] <= (div_q[DIVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
            if (cnt_r[idx] < AVG_DEPTH) cnt_r[idx] <= cnt_r[idx] + 8'd1;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_ok_r    <= ok_r;
            out_date_r  <= cur_date_r[62:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_date_r, out_ok_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while a word is in progress");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_refs_range: assert property (@(posedge clk) disable iff (!rst_n)
    refs_held_r != 2'd3 && refs_dec_r != 2'd3)
    else $error("reference count out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= AVG_DEPTH && cnt_r[1] <= AVG_DEPTH && cnt_r[2] <= AVG_DEPTH)
    else $error("sample count beyond averaging depth");

endmodule
`default_nettype wire

### sim/video_frame_drop_decider_tb.sv
// ----------------------------------------------------------------------------
// video_frame_drop_decider_tb - self-checking bench for the frame drop decider
// Drives timed events (directed corners, well-formed GOP streams, noise) with
// random idling on both sides, predicts decode_ok and the presentation date
// for every word and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module video_frame_drop_decider_tb;
  import vfdd_pkg::*;

  localparam int          AVG_DEPTH  = 8;
  localparam longint      RATE_ONE   = 1000;
  localparam longint      TICKS      = 1000000;
  localparam longint      DROP_MARGIN = TICKS * 75 / 1000;
  localparam longint unsigned FIRST_LIMIT = TICKS * 3 / 10;

  typedef struct {
    logic [2:0]  op;
    logic [62:0] now;
    logic [1:0]  ptype;
    logic [23:0] render;
    logic [1:0]  rep;
    logic [62:0] npts;
    logic [62:0] ndts;
    logic [15:0] rate;
    logic        garbage;
  } event_t;

  typedef struct {
    logic        ok;
    logic [62:0] date;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [239:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [17:0]  cfg_wdata = '0;

  video_frame_drop_decider dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // decider model state
  int unsigned       m_rate, m_never;
  int unsigned       m_mean [3];
  int unsigned       m_cnt [3];
  int unsigned       m_p_gop, m_p_seen, m_b_ref, m_b_seen;
  int unsigned       m_refs, m_refs_trash, m_refs_dec;
  longint unsigned   m_cur_date, m_bwd_date, m_dec_start;
  int unsigned       m_cur_f, m_bwd_f, m_st_rate, m_st_render;

  verdict_t verdict_q[$];
  int       errors = 0;
  int       words_sent = 0;
  bit       in_idle_on = 1'b1;
  bit       out_idle_on = 1'b1;
  int       out_wait = 0;
  int       out_hold = 0;

  function automatic void model_reset();
    m_rate = 25025; m_never = 0;
    for (int i = 0; i < 3; i++) begin
      m_mean[i] = 0; m_cnt[i] = 0;
    end
    m_p_gop = 5; m_p_seen = 5; m_b_ref = 1; m_b_seen = 1;
    m_refs = 0; m_refs_trash = 0; m_refs_dec = 0;
    m_cur_date = 0; m_bwd_date = 0; m_dec_start = 0;
    m_cur_f = 0; m_bwd_f = 0; m_st_rate = RATE_ONE; m_st_render = 0;
  endfunction

  function automatic longint frame_period(int unsigned rate);
    longint fr;
    fr = (m_rate != 0) ? longint'(m_rate) : 1;
    return 64'sd1001000000 / fr * longint'(rate) / RATE_ONE;
  endfunction

  function automatic longint tau(int idx);
    longint m;
    m = longint'(m_mean[idx]);
    return m + (m >>> 1) + longint'(m_st_render);
  endfunction

  function automatic logic choose_verdict(longint unsigned now, int unsigned ptype,
                                          int unsigned render);
    longint period, lim, k;
    longint unsigned pts;
    logic dec;
    dec = 1'b0;
    if (m_never != 0) return 1'b1;
    period = frame_period(m_st_rate);
    m_st_render = render;
    lim = (1 + longint'(m_p_gop) * (longint'(m_b_ref) + 1)) * period;
    if (ptype == PIC_I) begin
      pts = (m_bwd_date != 0) ? m_bwd_date
          : m_cur_date + longint'(period * (longint'(m_b_ref) + 2));
      if (lim > longint'(m_mean[0])) dec = 1'b1;
      else dec = longint'(pts - now) > tau(0) + DROP_MARGIN;
    end else if (ptype == PIC_P) begin
      pts = (m_bwd_date != 0) ? m_bwd_date
          : m_cur_date + longint'(period * (longint'(m_b_ref) + 1));
      if (m_refs < 1 || !(lim > longint'(m_mean[0]))) begin
        dec = 1'b0;
      end else if ((longint'(m_b_ref) + 1) * period > longint'(m_mean[1])) begin
        dec = longint'(pts - now) > 0;
      end else begin
        k = (longint'(m_p_gop) - longint'(m_p_seen)) * (1 + longint'(m_b_ref)) - 1;
        dec = longint'(pts - now) > tau(1) + DROP_MARGIN;
        dec = dec && (longint'((pts - now) + longint'(period * k))
                      > tau(1) + tau(0) + DROP_MARGIN);
      end
    end else if (ptype == PIC_B) begin
      // B pictures weigh the pattern against the P decode mean
      if (m_refs >= 2 && (longint'(m_b_ref) + 1) * period > longint'(m_mean[1]))
        dec = longint'(m_cur_date - now) > tau(2) + DROP_MARGIN;
    end
    return dec;
  endfunction

  function automatic void take_sample(longint unsigned now, int unsigned ptype, logic garbage);
    int idx;
    longint e;
    longint unsigned el, cnt, mean, nm;
    if (garbage || ptype < 1) return;
    idx = ptype - 1;
    e = longint'(now - m_dec_start);
    el = (e < 0) ? 0 : longint'(e);
    cnt = m_cnt[idx];
    mean = m_mean[idx];
    if (el < 3 * mean || (cnt == 0 && el < FIRST_LIMIT)) begin
      nm = (cnt * mean + el) / (cnt + 1);
      m_mean[idx] = (nm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nm[31:0];
      if (cnt < AVG_DEPTH) m_cnt[idx] = (cnt + 1) & 8'hFF;
    end
  endfunction

  function automatic void open_picture(event_t ev);
    longint period;
    period = frame_period(ev.rate);
    m_st_rate = ev.rate;
    if (ev.ptype == PIC_I) begin
      if (m_p_seen != 0 && m_p_seen != m_p_gop) m_p_gop = m_p_seen;
      m_p_seen = 0; m_b_seen = 0; m_refs_trash = 0;
      m_refs_dec = (m_refs < 2) ? m_refs + 1 : m_refs;
    end else if (ev.ptype == PIC_P) begin
      m_p_seen = (m_p_seen + 1) & 8'hFF;
      if (m_b_seen != 0 && m_b_seen != m_b_ref) m_b_ref = m_b_seen;
      m_b_seen = 0; m_refs_dec = 2; m_refs_trash = 0;
    end else if (ev.ptype == PIC_B) begin
      m_b_seen = (m_b_seen + 1) & 8'hFF;
      m_refs_dec = m_refs; m_refs_trash = m_refs;
    end
    m_cur_date += longint'(longint'(m_cur_f) * (period >>> 1));
    if (ev.ptype == PIC_B) begin
      m_cur_f = ev.rep;
      if (ev.npts != 0) m_cur_date = ev.npts;
    end else begin
      m_cur_f = m_bwd_f;
      m_bwd_f = ev.rep;
      if (m_bwd_date != 0) begin
        m_cur_date = m_bwd_date; m_bwd_date = 0;
      end else if (ev.ndts != 0) begin
        m_cur_date = ev.ndts;
      end
      if (ev.npts != 0) m_bwd_date = ev.npts;
    end
  endfunction

  function automatic verdict_t apply_event(event_t ev);
    verdict_t v;
    v.ok = 1'b0;
    case (ev.op)
      OP_NEW_PIC:   open_picture(ev);
      OP_CHOOSE:    v.ok = choose_verdict(ev.now, ev.ptype, ev.render);
      OP_TRASH:     m_refs = m_refs_trash;
      OP_DEC_START: begin
        m_dec_start = ev.now; m_refs = m_refs_dec;
      end
      OP_DEC_END:   take_sample(ev.now, ev.ptype, ev.garbage);
      OP_RESET: begin
        m_refs = 0; m_refs_trash = 0; m_refs_dec = 0;
      end
      default: ;
    endcase
    v.date = m_cur_date[62:0];
    return v;
  endfunction

  task automatic send_word(event_t ev);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev.op;
    in_tdata  <= {6'b0, ev.garbage, ev.rate, ev.ndts, ev.npts, ev.rep, ev.render,
                  ev.ptype, ev.now};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    verdict_q.push_back(apply_event(ev));
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [17:0] val);
    drain();
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_FPS_RATE) m_rate = val;
    else m_never = val[0];
    cfg_wr_en <= 1'b0;
  endtask

  function automatic event_t blank_event(logic [2:0] op);
    event_t ev;
    ev = '{op: op, now: '0, ptype: PIC_I, render: '0, rep: 2'd2, npts: '0,
           ndts: '0, rate: 16'd1000, garbage: 1'b0};
    return ev;
  endfunction

  function automatic event_t noise_event();
    event_t ev;
    ev.op      = $urandom_range(0, 7);
    ev.now     = {$urandom, $urandom};
    ev.ptype   = $urandom_range(0, 3);
    ev.render  = $urandom;
    ev.rep     = $urandom;
    ev.npts    = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
    ev.ndts    = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
    ev.rate    = $urandom;
    ev.garbage = $urandom;
    return ev;
  endfunction

  task automatic test_directed();
    event_t ev;
    ev = blank_event(OP_NEW_PIC);
    ev.ptype = PIC_I; ev.npts = '1; ev.ndts = 63'd40000; ev.rate = '1; ev.rep = 2'd3;
    send_word(ev);
    ev = blank_event(OP_NEW_PIC); ev.ptype = PIC_P; ev.npts = 63'd120000; send_word(ev);
    ev = blank_event(OP_NEW_PIC); ev.ptype = PIC_B; ev.npts = 63'd80000; ev.rate = '0;
    send_word(ev);
    ev = blank_event(OP_NEW_PIC); ev.ptype = PIC_NONE; ev.rep = 2'd0; send_word(ev);
    for (int t = 0; t < 4; t++) begin
      ev = blank_event(OP_CHOOSE); ev.ptype = t; ev.render = '1; ev.now = 63'd1000;
      send_word(ev);
    end
    ev = blank_event(OP_DEC_START); ev.now = 63'd5000; send_word(ev);
    ev = blank_event(OP_DEC_END); ev.now = 63'd25000; ev.ptype = PIC_I; send_word(ev);
    ev = blank_event(OP_DEC_END); ev.now = 63'd25000; ev.ptype = PIC_P; ev.garbage = 1'b1;
    send_word(ev);
    // elapsed time below zero counts as nothing
    ev = blank_event(OP_DEC_END); ev.now = 63'd10; ev.ptype = PIC_B; send_word(ev);
    ev = blank_event(OP_DEC_END); ev.now = 63'd9000; ev.ptype = PIC_NONE; send_word(ev);
    ev = blank_event(OP_DEC_START); ev.now = '0; send_word(ev);
    // first sample too big to accept, then a huge elapsed time
    ev = blank_event(OP_DEC_END); ev.now = 63'd400000; ev.ptype = PIC_P; send_word(ev);
    ev = blank_event(OP_DEC_END); ev.now = '1; ev.ptype = PIC_I; send_word(ev);
    ev = blank_event(OP_TRASH); send_word(ev);
    ev = blank_event(OP_RESET); send_word(ev);
    ev = blank_event(3'd6); ev.now = '1; send_word(ev);
    ev = blank_event(3'd7); send_word(ev);
    ev = blank_event(OP_CHOOSE); ev.ptype = PIC_B; ev.now = '1; send_word(ev);
  endtask

  // well-formed GOPs with random content, a little noise mixed in
  task automatic test_streams(int words);
    event_t ev;
    longint unsigned t;
    int n_p, n_b, ptype, stop_at;
    t = $urandom_range(0, 1000000);
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      n_p = $urandom_range(0, 6);
      n_b = $urandom_range(0, 3);
      for (int pic = 0; pic <= n_p * (n_b + 1) && words_sent < stop_at; pic++) begin
        if (pic == 0) ptype = PIC_I;
        else if (pic % (n_b + 1) == 0) ptype = PIC_P;
        else ptype = PIC_B;
        t += $urandom_range(10000, 50000);
        ev = blank_event(OP_NEW_PIC);
        ev.ptype = ptype; ev.now = t; ev.rep = $urandom_range(1, 3);
        ev.npts = ($urandom_range(0, 4) == 0) ? 0 : t + $urandom_range(0, 200000);
        ev.ndts = ($urandom_range(0, 2) == 0) ? 0 : t;
        ev.rate = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4000) : 1000;
        send_word(ev);
        ev.op = OP_CHOOSE; ev.now = t + $urandom_range(0, 20000);
        ev.render = $urandom_range(0, 30000);
        send_word(ev);
        if ($urandom_range(0, 4) == 0) begin
          ev.op = OP_TRASH; send_word(ev);
        end else begin
          ev.op = OP_DEC_START; send_word(ev);
          ev.op = OP_DEC_END; ev.now = ev.now + $urandom_range(0, 70000);
          ev.garbage = ($urandom_range(0, 9) == 0);
          send_word(ev);
        end
        if ($urandom_range(0, 29) == 0) send_word(blank_event(OP_RESET));
        if ($urandom_range(0, 6) == 0) send_word(noise_event());
      end
    end
  endtask

  task automatic test_noise(int words);
    repeat (words) send_word(noise_event());
  endtask

  // hold the output back while the sender keeps offering
  task automatic test_backpressure();
    in_idle_on = 1'b0;
    out_hold = 300;
    test_streams(12);
    in_idle_on = 1'b1;
  endtask

  task automatic test_config_sweep();
    logic [17:0] rates [6];
    rates = '{18'd1000, 18'd240000, 18'd0, 18'h3FFFF, 18'd30000, 18'd25025};
    foreach (rates[i]) begin
      write_reg(CFG_FPS_RATE, rates[i]);
      write_reg(CFG_NEVER_SKIP, (i == 1) ? 18'd1 : 18'd0);
      out_idle_on = (i != 3);
      in_idle_on  = (i != 4);
      test_streams(110);
      test_noise(10);
    end
    in_idle_on = 1'b1; out_idle_on = 1'b1;
  endtask

  // checker and receiver idling: check at the falling edge, word taken at the next rise
  always @(negedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.ok) begin
          $display("%0t: decode_ok expected %0b actual %0b", $time, want.ok, out_tdata[0]);
          errors++;
        end
        if (out_tdata[63:1] !== want.date) begin
          $display("%0t: presentation_date expected %0d actual %0d", $time, want.date,
                   out_tdata[63:1]);
          errors++;
        end
      end
      out_wait = out_idle_on ? $urandom_range(0, 4) : 0;
    end
  end

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (out_wait > 0) begin
      out_tready <= 1'b0;
      out_wait <= out_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config_sweep();
    write_reg(CFG_NEVER_SKIP, 18'd0);
    drain();
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
